@@ src/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and types of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int POOL_ORDER = 8;
   localparam int MIN_ORDER  = 3;

   localparam int GIDX_W   = (POOL_ORDER > MIN_ORDER) ? POOL_ORDER - MIN_ORDER : 1;
   localparam int GRANULES = 1 << (POOL_ORDER - MIN_ORDER);
   localparam int LINK_W   = GIDX_W + 1;
   localparam int LEVELS   = POOL_ORDER - MIN_ORDER + 1;
   localparam int LV_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   localparam int ORDER_W  = 4;
   localparam int ADDR_W   = 8;
   localparam int BYTES_W  = 9;
   localparam int STATUS_W = 3;

   localparam logic [LINK_W-1:0]  HEAD     = LINK_W'(GRANULES);
   localparam logic [ORDER_W-1:0] ORD_MIN  = ORDER_W'(MIN_ORDER);
   localparam logic [ORDER_W-1:0] ORD_POOL = ORDER_W'(POOL_ORDER);

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 4'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 4'd3;
   localparam logic [OP_W-1:0] OP_UNL0   = 4'd4;
   localparam logic [OP_W-1:0] OP_UNL1   = 4'd5;
   localparam logic [OP_W-1:0] OP_UNL2   = 4'd6;
   localparam logic [OP_W-1:0] OP_SPLIT  = 4'd7;
   localparam logic [OP_W-1:0] OP_PUSH0  = 4'd8;
   localparam logic [OP_W-1:0] OP_PUSH1  = 4'd9;
   localparam logic [OP_W-1:0] OP_MERGE  = 4'd10;

   typedef struct packed {
      logic                command;
      logic [BYTES_W-1:0]  request_bytes;
      logic [ADDR_W-1:0]   free_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   user_address;
      logic [ORDER_W-1:0]  block_order;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic mode;
      logic check_err;
      logic search_empty;
      logic search_hit;
      logic split_more;
      logic merge_ok;
   } dp_status_type;

endpackage

@@ src/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: steps the datapath through check, search, unlink, split,
// push and merge, and holds the result until transfer.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bba_pkg::dp_status_type dp_status,
   output bba_pkg::dp_cmd_type    dp_cmd
);
   import bba_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_SEARCH = 4'd2;
   localparam logic [3:0] S_UNL0   = 4'd3;
   localparam logic [3:0] S_UNL1   = 4'd4;
   localparam logic [3:0] S_UNL2   = 4'd5;
   localparam logic [3:0] S_SPLIT  = 4'd6;
   localparam logic [3:0] S_PUSH0  = 4'd7;
   localparam logic [3:0] S_PUSH1  = 4'd8;
   localparam logic [3:0] S_MERGE  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = OP_LOAD;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            dp_cmd.op = OP_CHECK;
            if (dp_status.check_err) begin
               state_in = S_DONE;
            end else if (dp_status.mode == CMD_FREE) begin
               state_in = S_MERGE;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            dp_cmd.op = OP_SEARCH;
            if (dp_status.search_empty) begin
               state_in = S_DONE;
            end else if (dp_status.search_hit) begin
               state_in = S_UNL0;
            end
         end
         S_UNL0: begin
            dp_cmd.op = OP_UNL0;
            state_in  = S_UNL1;
         end
         S_UNL1: begin
            dp_cmd.op = OP_UNL1;
            state_in  = S_UNL2;
         end
         S_UNL2: begin
            dp_cmd.op = OP_UNL2;
            state_in  = (dp_status.mode == CMD_FREE) ? S_MERGE : S_SPLIT;
         end
         S_SPLIT: begin
            dp_cmd.op = OP_SPLIT;
            state_in  = dp_status.split_more ? S_PUSH0 : S_DONE;
         end
         S_PUSH0: begin
            dp_cmd.op = OP_PUSH0;
            state_in  = S_PUSH1;
         end
         S_PUSH1: begin
            dp_cmd.op = OP_PUSH1;
            state_in  = (dp_status.mode == CMD_FREE) ? S_DONE : S_SPLIT;
         end
         S_MERGE: begin
            dp_cmd.op = OP_MERGE;
            state_in  = dp_status.merge_ok ? S_UNL0 : S_PUSH0;
         end
         S_DONE: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/bba_datapath.sv @@
// ----------------------------------------------------------------------------
// bba_datapath
// Granule tables, free list links and level fronts, with the working
// registers and result register of one command.
// ----------------------------------------------------------------------------
module bba_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bba_pkg::req_type       req_data,
   input  bba_pkg::dp_cmd_type    dp_cmd,
   output bba_pkg::dp_status_type dp_status,
   output bba_pkg::rsp_type       rsp_data
);
   import bba_pkg::*;

   logic                free_ff   [GRANULES];
   logic [ORDER_W-1:0]  order_ff  [GRANULES];
   logic                in_use_ff [GRANULES];
   logic [LINK_W-1:0]   fwd_ff    [GRANULES];
   logic [LINK_W-1:0]   bwd_ff    [GRANULES];
   logic [LINK_W-1:0]   front_ff  [LEVELS];

   logic                mode_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic [ADDR_W-1:0]   faddr_ff;
   logic [GIDX_W-1:0]   g_ff;
   logic [GIDX_W-1:0]   t_ff;
   logic [ORDER_W-1:0]  j_ff;
   logic [ORDER_W-1:0]  k_ff;
   logic [LINK_W-1:0]   f_ff;
   logic [LINK_W-1:0]   b_ff;
   rsp_type             rsp_ff;

   logic [BYTES_W:0]    need;
   logic [ORDER_W-1:0]  kc;
   logic [15:0]         off;
   logic [15:0]         gfull;
   logic [GIDX_W-1:0]   gi;
   logic                bad_free;
   logic [ORDER_W-1:0]  kf_raw;
   logic [ORDER_W-1:0]  kf;
   logic [LV_W-1:0]     lv_j;
   logic [LINK_W-1:0]   front_j;
   logic [GIDX_W-1:0]   buddy_m;
   logic [GIDX_W-1:0]   buddy_s;
   logic [GIDX_W-1:0]   ord_raddr;
   logic [GIDX_W+MIN_ORDER-1:0] blk_off;
   logic [ADDR_W-1:0]   g_addr;

   always_comb begin
      need = {1'b0, bytes_ff} + (BYTES_W+1)'(1);
      kc   = 4'hF;
      for (int i = BYTES_W + 1; i >= 0; i--) begin
         if ({1'b0, need} <= ((BYTES_W+2)'(1) << i)) begin
            kc = ORDER_W'(i);
         end
      end
      if (kc < ORD_MIN) begin
         kc = ORD_MIN;
      end
   end

   assign off       = 16'(faddr_ff) - 16'd1;
   assign gfull     = off >> MIN_ORDER;
   assign gi        = gfull[GIDX_W-1:0];
   assign lv_j      = LV_W'(j_ff - ORD_MIN);
   assign front_j   = front_ff[lv_j];
   assign buddy_m   = g_ff ^ (GIDX_W'(1) << (j_ff - ORD_MIN));
   assign buddy_s   = g_ff ^ (GIDX_W'(1) << (j_ff - ORD_MIN - 4'd1));
   assign ord_raddr = (dp_cmd.op == OP_CHECK) ? gi : buddy_m;
   assign kf_raw    = order_ff[ord_raddr];
   assign kf        = (kf_raw < ORD_MIN || kf_raw > ORD_POOL) ? ORD_MIN : kf_raw;
   assign blk_off   = {g_ff, {MIN_ORDER{1'b0}}};
   assign g_addr    = ADDR_W'(blk_off) + 8'd1;

   assign bad_free = (faddr_ff == 8'd0) || (off[MIN_ORDER-1:0] != '0)
                     || (gfull >= 16'(GRANULES)) || !in_use_ff[gi];

   assign dp_status.mode         = mode_ff;
   assign dp_status.check_err    = (mode_ff == CMD_FREE) ? bad_free
                                   : (bytes_ff == '0 || kc > ORD_POOL);
   assign dp_status.search_empty = (j_ff > ORD_POOL);
   assign dp_status.search_hit   = (front_j != HEAD);
   assign dp_status.split_more   = (j_ff > k_ff);
   assign dp_status.merge_ok     = (j_ff < ORD_POOL) && free_ff[buddy_m]
                                   && (kf_raw == j_ff);

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      case (dp_cmd.op)
         OP_LOAD: begin
            mode_ff  <= req_data.command;
            bytes_ff <= req_data.request_bytes;
            faddr_ff <= req_data.free_address;
         end
         OP_CHECK: begin
            rsp_ff.user_address <= '0;
            rsp_ff.block_order  <= '0;
            if (mode_ff == CMD_FREE) begin
               rsp_ff.status <= bad_free ? ST_BAD_FREE : ST_OK;
               g_ff <= gi;
               j_ff <= kf;
            end else begin
               k_ff <= kc;
               j_ff <= kc;
               if (bytes_ff == '0) begin
                  rsp_ff.status <= ST_ZERO;
               end else if (kc > ORD_POOL) begin
                  rsp_ff.status <= ST_TOO_LARGE;
               end else begin
                  rsp_ff.status <= ST_OK;
               end
            end
         end
         OP_SEARCH: begin
            if (j_ff > ORD_POOL) begin
               rsp_ff.status <= ST_NO_MEM;
            end else if (front_j != HEAD) begin
               g_ff <= front_j[GIDX_W-1:0];
               t_ff <= front_j[GIDX_W-1:0];
            end else begin
               j_ff <= j_ff + 4'd1;
            end
         end
         OP_UNL0: begin
            f_ff <= fwd_ff[t_ff];
            b_ff <= bwd_ff[t_ff];
         end
         OP_UNL2: begin
            if (mode_ff == CMD_FREE) begin
               j_ff <= j_ff + 4'd1;
               if (t_ff < g_ff) begin
                  g_ff <= t_ff;
               end
            end
         end
         OP_SPLIT: begin
            if (j_ff > k_ff) begin
               j_ff <= j_ff - 4'd1;
               t_ff <= buddy_s;
            end else begin
               rsp_ff.user_address <= g_addr;
               rsp_ff.block_order  <= k_ff;
            end
         end
         OP_PUSH0: begin
            f_ff <= front_j;
         end
         OP_PUSH1: begin
            if (mode_ff == CMD_FREE) begin
               rsp_ff.user_address <= g_addr;
               rsp_ff.block_order  <= j_ff;
            end
         end
         OP_MERGE: begin
            t_ff <= dp_status.merge_ok ? buddy_m : g_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRANULES; i++) begin
            free_ff[i]   <= 1'b0;
            order_ff[i]  <= '0;
            in_use_ff[i] <= 1'b0;
            fwd_ff[i]    <= HEAD;
            bwd_ff[i]    <= HEAD;
         end
         for (int i = 0; i < LEVELS; i++) begin
            front_ff[i] <= HEAD;
         end
         free_ff[0]          <= 1'b1;
         order_ff[0]         <= ORD_POOL;
         front_ff[LEVELS-1]  <= '0;
      end else begin
         case (dp_cmd.op)
            OP_CHECK: begin
               if (mode_ff == CMD_FREE && !bad_free) begin
                  in_use_ff[gi] <= 1'b0;
               end
            end
            OP_UNL0: begin
               free_ff[t_ff] <= 1'b0;
            end
            OP_UNL1: begin
               if (b_ff == HEAD) begin
                  front_ff[lv_j] <= f_ff;
               end else begin
                  fwd_ff[b_ff[GIDX_W-1:0]] <= f_ff;
               end
            end
            OP_UNL2: begin
               if (f_ff != HEAD) begin
                  bwd_ff[f_ff[GIDX_W-1:0]] <= b_ff;
               end
            end
            OP_SPLIT: begin
               if (!(j_ff > k_ff)) begin
                  in_use_ff[g_ff] <= 1'b1;
                  order_ff[g_ff]  <= k_ff;
               end
            end
            OP_PUSH0: begin
               fwd_ff[t_ff]   <= front_j;
               bwd_ff[t_ff]   <= HEAD;
               front_ff[lv_j] <= {1'b0, t_ff};
               free_ff[t_ff]  <= 1'b1;
               order_ff[t_ff] <= j_ff;
            end
            OP_PUSH1: begin
               if (f_ff != HEAD) begin
                  bwd_ff[f_ff[GIDX_W-1:0]] <= {1'b0, t_ff};
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ src/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a 2^POOL_ORDER byte pool in 2^MIN_ORDER byte
// granules: allocate with split, free with buddy coalescing.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   req       req_valid / req_stall  req_data  (command, request_bytes, free_address)
//   rsp       rsp_valid / rsp_stall  rsp_data  (status, user_address, block_order)
//
// One command at a time, from transfer in to result out. An allocate or
// free walks over the levels (6 here), with three steps per unlink, three
// per split and four per merge.
// The result holds on rsp_data until transfer; req_stall stays high meanwhile.
// Reset loads the whole pool as one free block.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   bba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.user_address == '0 && rsp_data.block_order == '0))
      else $error("error result carries address or order");

   a_ok_order_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_OK) |->
         (rsp_data.block_order >= ORD_MIN && rsp_data.block_order <= ORD_POOL))
      else $error("block order out of range");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ST_BAD_FREE))
      else $error("undefined status code");

endmodule

@@ bench/tb_buddy_block_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Drives allocate and free commands into the buddy allocator under several
// idle and stall patterns, predicts each response with a granule-level model
// of the free lists, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
   import bba_pkg::*;

   class alloc_scoreboard;
      localparam int NG = GRANULES;

      bit              gr_free  [NG];
      logic [3:0]      gr_order [NG];
      bit              gr_used  [NG];
      int              fwd      [NG];
      int              bwd      [NG];
      int              front    [LEVELS];
      rsp_type         pending_rsp[$];
      int              mismatches;

      function new();
         for (int i = 0; i < NG; i++) begin
            gr_free[i] = 0; gr_order[i] = 0; gr_used[i] = 0;
            fwd[i] = NG; bwd[i] = NG;
         end
         for (int i = 0; i < LEVELS; i++) front[i] = NG;
         push_block(0, POOL_ORDER);
         mismatches = 0;
      endfunction

      function void push_block(int g, int k);
         int f;
         f = front[k - MIN_ORDER];
         fwd[g] = f;
         bwd[g] = NG;
         if (f != NG) bwd[f] = g;
         front[k - MIN_ORDER] = g;
         gr_free[g] = 1;
         gr_order[g] = 4'(k);
      endfunction

      function void unlink_block(int g, int k);
         int f, b;
         f = fwd[g];
         b = bwd[g];
         if (b == NG) front[k - MIN_ORDER] = f;
         else fwd[b] = f;
         if (f != NG) bwd[f] = b;
         gr_free[g] = 0;
      endfunction

      function bit is_allocated(int g);
         return gr_used[g];
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int k, j, g, b, off;
         e = '0;
         if (r.command == CMD_ALLOC) begin
            if (r.request_bytes == 0) e.status = ST_ZERO;
            else begin
               k = MIN_ORDER;
               while ((1 << k) < int'(r.request_bytes) + 1) k++;
               if (k > POOL_ORDER) e.status = ST_TOO_LARGE;
               else begin
                  j = k;
                  while (j <= POOL_ORDER && front[j - MIN_ORDER] == NG) j++;
                  if (j > POOL_ORDER) e.status = ST_NO_MEM;
                  else begin
                     g = front[j - MIN_ORDER];
                     unlink_block(g, j);
                     while (j > k) begin
                        j--;
                        push_block(g ^ (1 << (j - MIN_ORDER)), j);
                     end
                     gr_used[g] = 1;
                     gr_order[g] = 4'(k);
                     e.status = ST_OK;
                     e.user_address = 8'((g << MIN_ORDER) + 1);
                     e.block_order = 4'(k);
                  end
               end
            end
         end else begin
            off = int'(r.free_address) - 1;
            g = off >>> MIN_ORDER;
            if (r.free_address == 0 || (off & ((1 << MIN_ORDER) - 1)) != 0 || g >= NG
                || !gr_used[g]) e.status = ST_BAD_FREE;
            else begin
               k = gr_order[g];
               if (k < MIN_ORDER || k > POOL_ORDER) k = MIN_ORDER;
               gr_used[g] = 0;
               while (k < POOL_ORDER) begin
                  b = g ^ (1 << (k - MIN_ORDER));
                  if (!gr_free[b] || gr_order[b] != k) break;
                  unlink_block(b, k);
                  k++;
                  if (b < g) g = b;
               end
               push_block(g, k);
               e.status = ST_OK;
               e.user_address = 8'((g << MIN_ORDER) + 1);
               e.block_order = 4'(k);
            end
         end
         pending_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", a);
            return;
         end
         e = pending_rsp.pop_front();
         if (a.status !== e.status || a.user_address !== e.user_address
             || a.block_order !== e.block_order) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: status %0d/%0d addr %0d/%0d order %0d/%0d (exp/act)",
                        e.status, a.status, e.user_address, a.user_address,
                        e.block_order, a.block_order);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   int idle_pct = 0;
   int stall_pct = 0;
   int live_addr[$];
   alloc_scoreboard board;

   buddy_block_allocator dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   always @(negedge clock)
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

   // Hold valid after the transfer; the next request or drain() updates it.
   task automatic send_request(req_type r);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic allocate(int bytes);
      req_type r;
      r = '0;
      r.command = CMD_ALLOC;
      r.request_bytes = 9'(bytes);
      r.free_address = 8'($urandom);
      send_request(r);
   endtask

   task automatic release_addr(int a);
      req_type r;
      r = '0;
      r.command = CMD_FREE;
      r.free_address = 8'(a);
      r.request_bytes = 9'($urandom);
      send_request(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Recover the live block list from the model after each transfer.
   task automatic refresh_live();
      live_addr.delete();
      for (int g = 0; g < GRANULES; g++)
         if (board.is_allocated(g)) live_addr.push_back((g << MIN_ORDER) + 1);
   endtask

   task automatic random_phase(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         refresh_live();
         pick = $urandom_range(99);
         if (pick < 45) begin
            if ($urandom_range(3) == 0) allocate($urandom_range(511));
            else allocate($urandom_range(1, 40));
         end else if (pick < 90 && live_addr.size() > 0)
            release_addr(live_addr[$urandom_range(live_addr.size() - 1)]);
         else release_addr($urandom_range(255));
         drain();
      end
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: errors, extremes, full split and merge
      allocate(0);
      allocate(511);
      allocate(256);
      allocate(255);
      allocate(1);
      release_addr(0);
      release_addr(2);
      release_addr(255);
      release_addr(1);
      release_addr(1);
      for (int i = 0; i < 33; i++) allocate(7);
      drain();
      for (int g = 0; g < GRANULES; g++) release_addr((g << MIN_ORDER) + 1);
      allocate(8);
      allocate(127);
      allocate(128);
      drain();
      repeat (40) @(negedge clock);
      random_phase(155);
      idle_pct = 76;
      random_phase(155);
      idle_pct = 0; stall_pct = 76;
      random_phase(155);
      idle_pct = 8; stall_pct = 8;
      random_phase(155);
      drain();
      repeat (60) @(negedge clock);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

@@ filelist.f @@
src/bba_pkg.sv
src/bba_ctrl.sv
src/bba_datapath.sv
src/buddy_block_allocator.sv
bench/tb_buddy_block_allocator.sv
